// ===== rtl/qcev_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcev_pkg
// Shared widths, register indexes and divider handshake types for the
// encoder count extension and velocity core.
// ----------------------------------------------------------------------------
package qcev_pkg;

  localparam int unsigned TIMER_W  = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned DIST_W   = 48;
  localparam int unsigned RELOAD_W = 16;
  localparam int unsigned DPT_W    = 32;
  localparam int unsigned WRAP_W   = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // |1000 * tick change| stays below 2^42
  localparam int unsigned DIV_W     = 42;
  localparam int unsigned DIV_CNT_W = 6;
  localparam int unsigned DEN_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RELOAD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DPT    = 8'd1;

  localparam logic [RELOAD_W-1:0] RELOAD_RST = 16'hFFFF;
  localparam logic [DPT_W-1:0]    DPT_RST    = 32'h0001_0000;

  localparam logic signed [10:0] MS_PER_S = 11'sd1000;

  localparam logic [TICK_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;
  localparam logic [TICK_W-1:0] SPEED_MIN = 32'h8000_0000;
  localparam logic [DIST_W-1:0] DIST_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [DIST_W-1:0] DIST_MIN  = 48'h8000_0000_0000;

  localparam logic signed [WRAP_W-1:0] WRAP_MAX = 16'sh7FFF;
  localparam logic signed [WRAP_W-1:0] WRAP_MIN = 16'sh8000;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/qcev_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcev channel interfaces
// Valid/ready channels for event beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface qcev_in_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic                              side;
  logic [qcev_pkg::TIMER_W-1:0]      timer_count;
  logic [qcev_pkg::TIMER_W-1:0]      capture_compare;
  logic [qcev_pkg::TIME_W-1:0]       time_ms;

  modport source (output valid, operation, side, timer_count, capture_compare, time_ms,
                  input ready);
  modport sink (input valid, operation, side, timer_count, capture_compare, time_ms,
                output ready);
endinterface

interface qcev_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [qcev_pkg::TICK_W-1:0] tick_position;
  logic signed [qcev_pkg::TICK_W-1:0] ticks_per_second;
  logic signed [qcev_pkg::DIST_W-1:0] distance;
  logic                              encoder_side;

  modport source (output valid, tick_position, ticks_per_second, distance, encoder_side,
                  input ready);
  modport sink (input valid, tick_position, ticks_per_second, distance, encoder_side,
                output ready);
endinterface

interface qcev_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [qcev_pkg::CFG_IDX_W-1:0]     index;
  logic [qcev_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/qcev_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcev_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qcev_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qcev_pkg::div_req_t  req_i,
  output qcev_pkg::div_rsp_t  rsp_o
);

  logic                               busy_q;
  logic                               done_q;
  logic [qcev_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [qcev_pkg::DIV_W-1:0]         num_q;
  logic [qcev_pkg::DEN_W-1:0]         den_q;
  logic [qcev_pkg::DEN_W-1:0]         rem_q;
  logic [qcev_pkg::DEN_W:0]           trial;
  logic [qcev_pkg::DEN_W:0]           diff;
  logic                               qbit;

  assign trial = {rem_q, num_q[qcev_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == qcev_pkg::DIV_CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= qcev_pkg::DIV_CNT_W'(qcev_pkg::DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - qcev_pkg::DIV_CNT_W'(1);
        if (cnt_q == qcev_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[qcev_pkg::DIV_W-2:0], qbit};
      rem_q <= qbit ? diff[qcev_pkg::DEN_W-1:0] : trial[qcev_pkg::DEN_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

// ===== rtl/quadrature_count_extend_velocity_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_count_extend_velocity_core
// Two-side encoder count extension with speed and distance reporting.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : event beats. operation 0 is a timer wrap, which nudges that side's
//           wrap count toward the compare value and gives no result beat.
//           operation 1 is a sample, which gives one beat on res_o.
//   res_o : tick position, ticks per second, Q32.16 distance, side echo.
//   cfg_i : register writes (0 reload value, 1 distance per tick), always
//           ready; write only while no sample is in flight.
// Timing:
//   a wrap beat is absorbed while the core stays idle, ready stays high.
//   a sample passes through the extend, multiply and divider start steps,
//   then the divider steps, then waits to load its result, and the next beat
//   can be taken once that result is loaded; the speed divider retires one
//   quotient bit a cycle, and with zero elapsed time the divider is skipped.
//   in_i is not ready while a sample is in work.
// Stall: the result sits in an output register; the next beat is accepted
//   while it waits, and a finished sample holds until res_o drains.
// Reset: wrap counts, last ticks and last times clear to zero, registers
//   return to reload 65535 and distance per tick 1.0.
// ----------------------------------------------------------------------------
module quadrature_count_extend_velocity_core #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qcev_in_if.sink   in_i,
  qcev_out_if.source res_o,
  qcev_cfg_if.sink  cfg_i
);

  localparam int unsigned CNT_W = (COUNT_BITS < qcev_pkg::TIMER_W) ? COUNT_BITS
                                                                    : qcev_pkg::TIMER_W;
  localparam logic [qcev_pkg::TIMER_W:0]   CNT_ONE  = 17'd1;
  localparam logic [qcev_pkg::TIMER_W-1:0] CNT_MASK =
    qcev_pkg::TIMER_W'((CNT_ONE << CNT_W) - CNT_ONE);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXT   = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  logic [qcev_pkg::RELOAD_W-1:0]           reload_q;
  logic [qcev_pkg::DPT_W-1:0]              dpt_q;
  logic signed [qcev_pkg::WRAP_W-1:0]      wrap_q [2];
  logic [qcev_pkg::TICK_W-1:0]             last_ticks_q [2];
  logic [qcev_pkg::TIME_W-1:0]             last_time_q [2];

  logic                                    side_q;
  logic [qcev_pkg::TIMER_W-1:0]            count_q;
  logic [qcev_pkg::TIME_W-1:0]             now_q;
  logic [qcev_pkg::TICK_W-1:0]             ticks_q;
  logic [qcev_pkg::DIV_W-1:0]              mag_q;
  logic                                    neg_q;
  logic                                    dzero_q;
  logic [qcev_pkg::TIME_W-1:0]             elapsed_q;
  logic signed [63:0]                      dprod_q;
  logic [qcev_pkg::DIST_W-1:0]             dist_q;
  logic [qcev_pkg::TICK_W-1:0]             speed_q;

  logic                                    out_valid_q;

  logic                                    in_acc;
  logic [qcev_pkg::TIMER_W-1:0]            count_in;
  logic signed [qcev_pkg::WRAP_W-1:0]      wrap_cur;
  logic signed [qcev_pkg::WRAP_W-1:0]      wrap_next;
  logic signed [32:0]                      wr_prod;
  logic [qcev_pkg::TICK_W-1:0]             ext;
  logic [qcev_pkg::TICK_W-1:0]             ticks_d;
  logic [qcev_pkg::TICK_W-1:0]             last_sel;
  logic signed [32:0]                      delta;
  logic signed [42:0]                      scaled;
  logic [42:0]                             scaled_abs;
  logic signed [63:0]                      dprod;
  logic [qcev_pkg::DIST_W-1:0]             dist_sat;
  logic [qcev_pkg::TICK_W-1:0]             speed_zero;
  logic [qcev_pkg::TICK_W-1:0]             speed_div;
  logic                                    load_out;

  qcev_pkg::div_req_t div_req;
  qcev_pkg::div_rsp_t div_rsp;

  qcev_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign count_in    = in_i.timer_count & CNT_MASK;

  // wrap count step toward the compare value
  always_comb begin
    wrap_cur  = wrap_q[in_i.side];
    wrap_next = wrap_cur;
    if ((in_i.capture_compare > count_in) && (wrap_cur != qcev_pkg::WRAP_MAX)) begin
      wrap_next = wrap_cur + 16'sd1;
    end else if ((in_i.capture_compare < count_in) && (wrap_cur != qcev_pkg::WRAP_MIN)) begin
      wrap_next = wrap_cur - 16'sd1;
    end
  end

  // extended position
  assign wr_prod = wrap_q[side_q] * $signed({1'b0, reload_q});
  assign ext     = wr_prod[31:0] + {16'd0, count_q};
  assign ticks_d = side_q ? (32'd0 - ext) : ext;

  // tick change, scaled change and distance product
  assign last_sel   = last_ticks_q[side_q];
  assign delta      = $signed({ticks_q[31], ticks_q}) - $signed({last_sel[31], last_sel});
  assign scaled     = delta * qcev_pkg::MS_PER_S;
  assign scaled_abs = scaled[42] ? (43'd0 - scaled) : scaled;
  assign dprod      = $signed(ticks_q) * $signed({1'b0, dpt_q});

  always_comb begin
    if (!dprod_q[63] && (dprod_q[62:47] != 16'h0000)) begin
      dist_sat = qcev_pkg::DIST_MAX;
    end else if (dprod_q[63] && (dprod_q[62:47] != 16'hFFFF)) begin
      dist_sat = qcev_pkg::DIST_MIN;
    end else begin
      dist_sat = dprod_q[47:0];
    end
  end

  always_comb begin
    if (dzero_q) begin
      speed_zero = '0;
    end else if (neg_q) begin
      speed_zero = qcev_pkg::SPEED_MIN;
    end else begin
      speed_zero = qcev_pkg::SPEED_MAX;
    end
  end

  always_comb begin
    if (neg_q) begin
      if ((div_rsp.quot[41:32] != '0) || (div_rsp.quot[31] && (div_rsp.quot[30:0] != '0))) begin
        speed_div = qcev_pkg::SPEED_MIN;
      end else begin
        speed_div = 32'd0 - div_rsp.quot[31:0];
      end
    end else if (div_rsp.quot[41:31] != '0) begin
      speed_div = qcev_pkg::SPEED_MAX;
    end else begin
      speed_div = div_rsp.quot[31:0];
    end
  end

  assign div_req.start = (state_q == ST_START) && (elapsed_q != '0);
  assign div_req.num   = mag_q;
  assign div_req.den   = elapsed_q;

  assign load_out = (state_q == ST_DONE) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.operation) begin
          state_d = ST_EXT;
        end
      end
      ST_EXT:   state_d = ST_MUL;
      ST_MUL:   state_d = ST_START;
      ST_START: state_d = (elapsed_q == '0) ? ST_DONE : ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      reload_q        <= qcev_pkg::RELOAD_RST;
      dpt_q           <= qcev_pkg::DPT_RST;
      wrap_q[0]       <= '0;
      wrap_q[1]       <= '0;
      last_ticks_q[0] <= '0;
      last_ticks_q[1] <= '0;
      last_time_q[0]  <= '0;
      last_time_q[1]  <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == qcev_pkg::REG_RELOAD) begin
          reload_q <= cfg_i.data[qcev_pkg::RELOAD_W-1:0];
        end else if (cfg_i.index == qcev_pkg::REG_DPT) begin
          dpt_q <= cfg_i.data[qcev_pkg::DPT_W-1:0];
        end
      end
      if (in_acc && !in_i.operation) begin
        wrap_q[in_i.side] <= wrap_next;
      end
      if (load_out) begin
        last_ticks_q[side_q] <= ticks_q;
        last_time_q[side_q]  <= now_q;
        out_valid_q          <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      side_q  <= in_i.side;
      count_q <= count_in;
      now_q   <= in_i.time_ms;
    end
    if (state_q == ST_EXT) begin
      ticks_q <= ticks_d;
    end
    if (state_q == ST_MUL) begin
      mag_q     <= scaled_abs[qcev_pkg::DIV_W-1:0];
      neg_q     <= delta[32];
      dzero_q   <= (delta == '0);
      elapsed_q <= now_q - last_time_q[side_q];
      dprod_q   <= dprod;
    end
    if (state_q == ST_START) begin
      dist_q  <= dist_sat;
      speed_q <= speed_zero;
    end
    if ((state_q == ST_DIV) && div_rsp.done) begin
      speed_q <= speed_div;
    end
    if (load_out) begin
      res_o.tick_position    <= ticks_q;
      res_o.ticks_per_second <= speed_q;
      res_o.distance         <= dist_q;
      res_o.encoder_side     <= side_q;
    end
  end

  assign res_o.valid = out_valid_q;

endmodule

// ===== rtl/qcev_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcev_checker
// Port-level checks for the encoder extension core, bound to the top level.
// ----------------------------------------------------------------------------
module qcev_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic in_op,
  input logic out_valid,
  input logic out_ready
);

  // result beat holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a sample beat occupies the core
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_op |=> !in_ready)
    else $error("ready stayed high after a sample beat");

  // a wrap beat is absorbed at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && !in_op |=> in_ready)
    else $error("wrap beat stalled the core");

  // results only come from sample work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result beat without sample work");

endmodule

bind quadrature_count_extend_velocity_core qcev_checker u_qcev_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_op     (in_i.operation),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready)
);
